// ----- rtl/pmpc_pkg.sv -----
// pmpc_pkg: shared types and constants for the ps/2 mouse packet cursor
// header bit positions, byte phase encoding, register indexes and reset sizes
// no dependencies
package pmpc_pkg;

  // configuration register file
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned SizeW    = 13;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SizeW-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [SizeW-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // packet header bit positions
  localparam int unsigned HdrLeftBit  = 0;
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned HdrXOvflBit = 6;
  localparam int unsigned HdrYOvflBit = 7;

  // signed motion delta, wide enough for the negated 9-bit value
  localparam int unsigned DeltaW = 10;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XBYTE  = 2'd1,
    PH_YBYTE  = 2'd2
  } phase_e;

endpackage

// ----- rtl/ps2_mouse_packet_cursor.sv -----
// ps2_mouse_packet_cursor: ps/2 mouse 3-byte packet decoder with clamped cursor
// single module, output register plus one skid entry on the result side
// depends on pmpc_pkg
//
// Takes one request per clock unless stalled: a controller byte plus a flag
// that marks it as mouse data; non-mouse bytes leave all state alone. Mouse
// bytes build the usual three-byte packet (header, x delta, y delta), and a
// header is taken only with bit 3 set so the decoder falls back into step after
// a lost byte. On the third byte the 9-bit deltas get their sign from header
// bits 4 and 5, both go to zero if either overflow bit is set, the left button
// follows header bit 0 and the cursor moves by +dx and -dy (top of screen is
// zero), clamped to 0..size-1. Every request yields exactly one result carrying
// the current cursor, the left button and a packet_done flag. Throughput is one
// request per cycle while in_stall_o is low; results go through a single result
// register. While a result waits on out_stall_i, one more request is taken into
// a skid entry, and only then does in_stall_o rise. Sizes of zero act as 1 and
// sizes above 2^COORD_BITS act as 2^COORD_BITS. Writing either size register
// recenters the cursor; write configuration only while no request is in flight.
module ps2_mouse_packet_cursor
  import pmpc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [SizeW-1:0]      cfg_wdata_i,
  // byte request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  from_mouse_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic                  left_button_o,
  output logic                  packet_done_o
);

  // effective size needs COORD_BITS+1 bits to hold 2^COORD_BITS
  localparam int unsigned SzW   = (COORD_BITS + 1 > SizeW) ? COORD_BITS + 1 : SizeW;
  localparam int unsigned SumW  = COORD_BITS + 2;
  localparam int unsigned ResW  = 2 * COORD_BITS + 2;
  localparam int unsigned MaxSz = 1 << COORD_BITS;

  localparam int unsigned EffWRst = (int'(SCREEN_WIDTH_RST) > MaxSz) ? MaxSz
                                    : int'(SCREEN_WIDTH_RST);
  localparam int unsigned EffHRst = (int'(SCREEN_HEIGHT_RST) > MaxSz) ? MaxSz
                                    : int'(SCREEN_HEIGHT_RST);
  localparam logic [COORD_BITS-1:0] PosXRst = COORD_BITS'(EffWRst / 2);
  localparam logic [COORD_BITS-1:0] PosYRst = COORD_BITS'(EffHRst / 2);

  function automatic logic [SzW-1:0] eff_size(logic [SizeW-1:0] v);
    logic [SzW-1:0] ext;
    logic [SzW-1:0] max_sz;
    ext    = SzW'(v);
    max_sz = SzW'(1) << COORD_BITS;
    if (v == '0) begin
      eff_size = SzW'(1);
    end else if (ext > max_sz) begin
      eff_size = max_sz;
    end else begin
      eff_size = ext;
    end
  endfunction

  // pos + d, clamped to 0..lim
  function automatic logic [COORD_BITS-1:0] move_clamp(logic [COORD_BITS-1:0] pos,
                                                       logic signed [DeltaW-1:0] d,
                                                       logic [COORD_BITS-1:0] lim);
    logic signed [SumW-1:0] p;
    p = $signed({2'b00, pos}) + SumW'(d);
    if (p[SumW-1]) begin
      move_clamp = '0;
    end else if (p > $signed({2'b00, lim})) begin
      move_clamp = lim;
    end else begin
      move_clamp = p[COORD_BITS-1:0];
    end
  endfunction

  // configuration and decoder state
  logic [SizeW-1:0]      width_q, width_d;
  logic [SizeW-1:0]      height_q, height_d;
  phase_e                phase_q, phase_d;
  logic [7:0]            header_q, header_d;
  logic [7:0]            xbyte_q, xbyte_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
  logic                  left_q, left_d;

  // result register and skid entry
  logic                  out_valid_q, out_valid_d;
  logic [ResW-1:0]       out_q, out_d;
  logic                  skid_valid_q, skid_valid_d;
  logic [ResW-1:0]       skid_q, skid_d;

  logic                  in_accept;
  logic                  out_take;
  logic                  done;
  logic [ResW-1:0]       result;
  logic [SzW-1:0]        eff_w, eff_h;
  logic [SzW-1:0]        eff_w_next, eff_h_next;
  logic signed [DeltaW-1:0] dx, dy;
  logic                  ovfl;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  assign eff_w = eff_size(width_q);
  assign eff_h = eff_size(height_q);

  // deltas from the stored header and x byte, y byte straight from the input
  assign ovfl = header_q[HdrXOvflBit] | header_q[HdrYOvflBit];
  assign dx   = ovfl ? '0 : $signed({header_q[HdrXSignBit], header_q[HdrXSignBit], xbyte_q});
  assign dy   = ovfl ? '0 : $signed({header_q[HdrYSignBit], header_q[HdrYSignBit], data_byte_i});

  // decoder next state
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    phase_d  = phase_q;
    header_d = header_q;
    xbyte_d  = xbyte_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    left_d   = left_q;
    done     = 1'b0;

    if (in_accept && from_mouse_i) begin
      case (phase_q)
        PH_XBYTE: begin
          xbyte_d = data_byte_i;
          phase_d = PH_YBYTE;
        end
        PH_YBYTE: begin
          left_d  = header_q[HdrLeftBit];
          pos_x_d = move_clamp(pos_x_q, dx, COORD_BITS'(eff_w - SzW'(1)));
          pos_y_d = move_clamp(pos_y_q, -dy, COORD_BITS'(eff_h - SzW'(1)));
          phase_d = PH_HEADER;
          done    = 1'b1;
        end
        default: begin
          // header: only a byte with the sync bit starts a packet
          header_d = data_byte_i;
          phase_d  = data_byte_i[HdrSyncBit] ? PH_XBYTE : PH_HEADER;
        end
      endcase
    end

    // a size write recenters on the new effective sizes
    if (cfg_we_i && (cfg_index_i == CFG_SCREEN_WIDTH || cfg_index_i == CFG_SCREEN_HEIGHT)) begin
      if (cfg_index_i == CFG_SCREEN_WIDTH) begin
        width_d = cfg_wdata_i;
      end else begin
        height_d = cfg_wdata_i;
      end
      pos_x_d = COORD_BITS'(eff_w_next >> 1);
      pos_y_d = COORD_BITS'(eff_h_next >> 1);
    end
  end

  assign eff_w_next = eff_size((cfg_index_i == CFG_SCREEN_WIDTH) ? cfg_wdata_i : width_q);
  assign eff_h_next = eff_size((cfg_index_i == CFG_SCREEN_HEIGHT) ? cfg_wdata_i : height_q);

  // result as seen after this request: position, button, done flag
  assign result = {pos_x_d, pos_y_d, left_d, done};

  // output register with one skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = in_accept;
      end
    end else if (in_accept) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= SCREEN_WIDTH_RST;
      height_q     <= SCREEN_HEIGHT_RST;
      phase_q      <= PH_HEADER;
      header_q     <= '0;
      xbyte_q      <= '0;
      pos_x_q      <= PosXRst;
      pos_y_q      <= PosYRst;
      left_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      phase_q      <= phase_d;
      header_q     <= header_d;
      xbyte_q      <= xbyte_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      left_q       <= left_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = out_q[ResW-1 -: COORD_BITS];
  assign cursor_y_o    = out_q[2 +: COORD_BITS];
  assign left_button_o = out_q[1];
  assign packet_done_o = out_q[0];

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while output register is empty");

  a_pos_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SzW'(pos_x_q) < eff_w)
    else $error("cursor x beyond screen width");

  a_pos_y_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SzW'(pos_y_q) < eff_h)
    else $error("cursor y beyond screen height");

  a_xbyte_synced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_XBYTE) |-> header_q[HdrSyncBit])
    else $error("packet started from header without sync bit");

  a_packet_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && from_mouse_i && phase_q == PH_YBYTE) |=> (phase_q == PH_HEADER))
    else $error("byte phase did not return to header after third byte");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for the ps/2 mouse packet cursor
// holds a cursor scoreboard class, byte and size-write driver tasks, a result monitor
// depends on pmpc_pkg and ps2_mouse_packet_cursor
`timescale 1ns / 1ps

module tb;
  import pmpc_pkg::*;

  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned MAX_SIZE     = 1 << COORD_BITS;
  // settle time before a size write, once every result is back
  localparam int unsigned SETTLE_CYCLES = 8;
  // long receiver hold-off that fills the output register and the skid entry
  localparam int unsigned HOLD_CYCLES  = 300;
  // cycles with no handshake on either channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT  = 4000;
  // register index with no register behind it, writes there must be ignored
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct {
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic                  left_button;
    logic                  packet_done;
  } cursor_result_t;

  // predicts the cursor after each accepted byte and checks the results in order
  class cursor_scoreboard;
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    phase_e           phase;
    logic [7:0]       header;
    logic [7:0]       x_byte;
    int unsigned      pos_x;
    int unsigned      pos_y;
    logic             left;
    cursor_result_t   expected_q[$];
    int unsigned      mismatches;

    function new();
      width_reg  = SCREEN_WIDTH_RST;
      height_reg = SCREEN_HEIGHT_RST;
      phase      = PH_HEADER;
      header     = '0;
      x_byte     = '0;
      left       = 1'b0;
      mismatches = 0;
      recenter();
    endfunction

    // zero acts as one, anything past the coordinate range acts as its full size
    function int unsigned usable_size(logic [SizeW-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIZE) return MAX_SIZE;
      return v;
    endfunction

    function void recenter();
      pos_x = usable_size(width_reg) / 2;
      pos_y = usable_size(height_reg) / 2;
    endfunction

    function int unsigned move_clamped(int unsigned pos, int delta, int unsigned size);
      int p;
      p = int'(pos) + delta;
      if (p < 0) p = 0;
      if (p > int'(size) - 1) p = int'(size) - 1;
      return p;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] value);
      case (idx)
        CFG_SCREEN_WIDTH: begin
          width_reg = value;
          recenter();
        end
        CFG_SCREEN_HEIGHT: begin
          height_reg = value;
          recenter();
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [7:0] data, logic mouse);
      cursor_result_t res;
      int             dx;
      int             dy;
      res.packet_done = 1'b0;
      if (mouse) begin
        case (phase)
          PH_XBYTE: begin
            x_byte = data;
            phase  = PH_YBYTE;
          end
          PH_YBYTE: begin
            dx = header[HdrXSignBit] ? int'(x_byte) - 256 : int'(x_byte);
            dy = header[HdrYSignBit] ? int'(data) - 256 : int'(data);
            if (header[HdrXOvflBit] || header[HdrYOvflBit]) begin
              dx = 0;
              dy = 0;
            end
            left  = header[HdrLeftBit];
            pos_x = move_clamped(pos_x, dx, usable_size(width_reg));
            pos_y = move_clamped(pos_y, -dy, usable_size(height_reg));
            phase = PH_HEADER;
            res.packet_done = 1'b1;
          end
          default: begin
            header = data;
            phase  = data[HdrSyncBit] ? PH_XBYTE : PH_HEADER;
          end
        endcase
      end
      res.cursor_x    = pos_x[COORD_BITS-1:0];
      res.cursor_y    = pos_y[COORD_BITS-1:0];
      res.left_button = left;
      expected_q.push_back(res);
    endfunction

    function void check_result(cursor_result_t got);
      cursor_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: x %0d y %0d", got.cursor_x, got.cursor_y);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.cursor_x !== exp_res.cursor_x) begin
        $error("cursor_x: expected %0d, actual %0d", exp_res.cursor_x, got.cursor_x);
        mismatches++;
      end
      if (got.cursor_y !== exp_res.cursor_y) begin
        $error("cursor_y: expected %0d, actual %0d", exp_res.cursor_y, got.cursor_y);
        mismatches++;
      end
      if (got.left_button !== exp_res.left_button) begin
        $error("left_button: expected %0d, actual %0d", exp_res.left_button,
               got.left_button);
        mismatches++;
      end
      if (got.packet_done !== exp_res.packet_done) begin
        $error("packet_done: expected %0d, actual %0d", exp_res.packet_done,
               got.packet_done);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // clock, reset and dut pins
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [SizeW-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = '0;
  logic                  from_mouse = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  left_button;
  logic                  packet_done;

  // run control shared by the driver, the receiver and the watchdog
  bit                    steady_run = 1'b0;   // last part: no idling on either side
  bit                    hold_off_req = 1'b0; // ask the receiver for one long stall
  int unsigned           quiet_cycles = 0;

  cursor_scoreboard sb = new();

  ps2_mouse_packet_cursor #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .from_mouse_i (from_mouse),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .cursor_x_o   (cursor_x),
    .cursor_y_o   (cursor_y),
    .left_button_o(left_button),
    .packet_done_o(packet_done)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // drop valid and let the input side sit for a while
  task automatic input_gap(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // offer one byte request, hold it until taken, then maybe idle a random burst
  task automatic offer_byte(logic [7:0] data, logic mouse);
    in_valid   <= 1'b1;
    data_byte  <= data;
    from_mouse <= mouse;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_request(data, mouse);
    if (!steady_run && $urandom_range(0, 4) == 0) input_gap($urandom_range(1, 16));
  endtask

  // one full packet; optionally slip a non-mouse byte between the motion bytes
  task automatic offer_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy,
                              bit with_foreign);
    offer_byte(hdr, 1'b1);
    offer_byte(dx, 1'b1);
    if (with_foreign) offer_byte(8'($urandom), 1'b0);
    offer_byte(dy, 1'b1);
  endtask

  // size writes only once every result is back and the pipeline has settled
  task automatic write_size(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
  endtask

  task automatic set_screen(logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    write_size(CFG_SCREEN_WIDTH, w);
    write_size(CFG_SCREEN_HEIGHT, h);
  endtask

  // mostly well-formed packets with random content, plus foreign bytes,
  // stray mouse bytes and packets cut short to force resyncs
  task automatic random_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  hdr;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        hdr = 8'($urandom);
        hdr[HdrSyncBit] = 1'b1;
        // overflow is rare in practice, keep most packets moving
        if ($urandom_range(0, 7) != 0) begin
          hdr[HdrXOvflBit] = 1'b0;
          hdr[HdrYOvflBit] = 1'b0;
        end
        offer_packet(hdr, 8'($urandom), 8'($urandom), $urandom_range(0, 9) == 0);
        sent += 3;
      end else if (pick < 90) begin
        offer_byte(8'($urandom), 1'b0);
        sent += 1;
      end else if (pick < 95) begin
        offer_byte(8'($urandom), 1'b1);
        sent += 1;
      end else begin
        hdr = 8'($urandom);
        hdr[HdrSyncBit] = 1'b1;
        offer_byte(hdr, 1'b1);
        offer_byte(8'($urandom), 1'b1);
        sent += 2;
      end
    end
  endtask

  // receiver: random stall and run bursts, one long hold-off on request,
  // and a steady stream of accepts at the end
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!steady_run && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat (steady_run ? 1 : $urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // result monitor and quiet-cycle count for the watchdog
  always @(posedge clk_i) begin
    cursor_result_t got;
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        got.cursor_x    = cursor_x;
        got.cursor_y    = cursor_y;
        got.left_button = left_button;
        got.packet_done = packet_done;
        sb.check_result(got);
      end
    end
  end

  // watchdog: no handshake for too long means the block is hung
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset sizes, cursor starts at the screen center
    offer_byte(8'hFF, 1'b0);                  // foreign byte, state untouched
    offer_byte(8'h00, 1'b1);                  // header without sync bit, dropped
    offer_byte(8'hF7, 1'b1);                  // all bits but sync, still dropped
    offer_packet(8'h09, 8'hFF, 8'h00, 1'b0);  // left press, largest positive x step
    offer_packet(8'h38, 8'h00, 8'h00, 1'b0);  // both deltas -256, y past the bottom
    offer_packet(8'hC9, 8'h7F, 8'h7F, 1'b0);  // both overflow bits, no motion
    offer_packet(8'h48, 8'h10, 8'h10, 1'b0);  // x overflow alone zeroes both
    offer_packet(8'h8C, 8'h10, 8'h10, 1'b0);  // y overflow alone zeroes both
    offer_packet(8'h0E, 8'h01, 8'hFF, 1'b1);  // middle and right set, foreign inside
    offer_packet(8'h18, 8'h80, 8'h7F, 1'b0);  // x -128, y up toward the top edge
    offer_packet(8'h28, 8'h00, 8'h01, 1'b0);  // y sign with byte 01, a delta of -255

    // size extremes, each write recenters the cursor
    set_screen(13'd0, 13'd0);                 // zero acts as one
    offer_packet(8'h08, 8'h7F, 8'h80, 1'b0);
    set_screen(13'h1FFF, 13'h1FFF);           // far beyond the coordinate range
    offer_packet(8'h29, 8'hFF, 8'h00, 1'b0);
    write_size(CFG_UNMAPPED, 13'h0ABC);       // unmapped index, no effect

    // random part across several screen sizes
    set_screen(13'd1, 13'd1);
    random_traffic(150);
    set_screen(13'd4096, 13'd4096);
    hold_off_req = 1'b1;                      // receiver backs up while bytes keep coming
    random_traffic(250);
    set_screen(13'd4097, 13'd2);
    random_traffic(200);
    set_screen(13'd640, 13'd480);
    random_traffic(250);
    set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    random_traffic(200);
    set_screen(13'($urandom), 13'($urandom));
    random_traffic(200);
    set_screen(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
    random_traffic(200);

    // last part runs flat out on both sides
    set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    steady_run = 1'b1;
    random_traffic(250);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pmpc_pkg.sv
rtl/ps2_mouse_packet_cursor.sv
tb/sv/tb.sv
